// ===== hdl/tsni_pkg.sv =====
`default_nettype none

package tsni_pkg;

    // default width of the payload length kept inside the block
    localparam int LENGTH_WIDTH_DEF = 16;

    // record and handshake markers
    localparam logic [7:0] TLS_HANDSHAKE = 8'h16;
    localparam logic [7:0] TLS_MAJOR     = 8'h03;
    localparam logic [7:0] CLIENT_HELLO  = 8'h01;

    // byte offsets checked in the record header
    localparam int OFS_CONTENT_TYPE = 0;
    localparam int OFS_VERSION_MAJ  = 1;
    localparam int OFS_HS_TYPE      = 5;
    // offset of the session id length byte
    localparam int OFS_SESSION_ID   = 43;
    // shortest payload worth parsing
    localparam int MIN_HELLO_LEN    = 45;

    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0]  NAME_TYPE_HOST  = 8'h00;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_HEADER = 4'd1,
        PH_CS_HI  = 4'd2,
        PH_CS_LO  = 4'd3,
        PH_COMP   = 4'd4,
        PH_EL_HI  = 4'd5,
        PH_EL_LO  = 4'd6,
        PH_ET_HI  = 4'd7,
        PH_ET_LO  = 4'd8,
        PH_XL_HI  = 4'd9,
        PH_XL_LO  = 4'd10,
        PH_NT     = 4'd11,
        PH_NM_HI  = 4'd12,
        PH_NM_LO  = 4'd13,
        PH_NAME   = 4'd14
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_NAME = 2'd1,
        KIND_MISS = 2'd2
    } res_kind_t;

    // one result word handed from the parser to the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] name_byte;
        logic       found;
        logic       final_res;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/tsni_parser.sv =====
`default_nettype none

module tsni_parser
    import tsni_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_en,
    input  wire logic [7:0]  payload_byte,
    input  wire logic [15:0] payload_length,
    input  wire logic        first_byte,
    input  wire logic        last_byte,
    output res_t             res
);

    localparam int PW = LENGTH_WIDTH + 1;
    // wide enough for an offset plus a 16-bit length plus small constants
    localparam int SW = ((PW > 16) ? PW : 16) + 2;
    localparam logic [PW-1:0] POS_MAX = '1;

    phase_t                  phase_reg, phase_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [PW-1:0]           tgt_reg, tgt_next;
    logic [PW-1:0]           ext_end_reg, ext_end_next;
    logic [LENGTH_WIDTH-1:0] total_reg, total_next;
    logic [7:0]              hold_reg, hold_next;
    logic [15:0]             ext_type_reg, ext_type_next;
    logic [15:0]             remain_reg, remain_next;
    logic                    decided_reg, decided_next;

    res_kind_t kind;
    logic      fin;

    function automatic logic [PW-1:0] sat(input logic [SW-1:0] v);
        if (v > SW'(POS_MAX))
            return POS_MAX;
        return v[PW-1:0];
    endfunction

    // parse step for one payload word
    always_comb
    begin
        logic [SW-1:0] p_w;
        logic [SW-1:0] off_w;
        logic [SW-1:0] t_w;
        logic [SW-1:0] tot_w;
        logic [SW-1:0] hb_w;
        logic [SW-1:0] b_w;
        logic          give_up;

        phase_next    = phase_reg;
        pos_next      = pos_reg;
        tgt_next      = tgt_reg;
        ext_end_next  = ext_end_reg;
        total_next    = total_reg;
        hold_next     = hold_reg;
        ext_type_next = ext_type_reg;
        remain_next   = remain_reg;
        decided_next  = decided_reg;
        kind          = KIND_NONE;
        fin           = 1'b0;
        give_up       = 1'b0;

        if (first_byte)
        begin
            decided_next  = 1'b0;
            phase_next    = PH_HEADER;
            pos_next      = '0;
            total_next    = payload_length[LENGTH_WIDTH-1:0];
            tgt_next      = PW'(OFS_SESSION_ID);
            ext_end_next  = '0;
            hold_next     = '0;
            ext_type_next = '0;
            remain_next   = '0;
            if (payload_length[LENGTH_WIDTH-1:0] < LENGTH_WIDTH'(MIN_HELLO_LEN))
                give_up = 1'b1;
        end

        p_w   = SW'(pos_next);
        tot_w = SW'(total_next);
        b_w   = SW'(payload_byte);
        hb_w  = SW'({hold_next, payload_byte});
        off_w = p_w + SW'(1);
        t_w   = '0;

        if (!decided_next && !give_up)
        begin
            if (phase_next == PH_HEADER)
            begin
                if ((p_w == SW'(OFS_CONTENT_TYPE) && payload_byte != TLS_HANDSHAKE) ||
                    (p_w == SW'(OFS_VERSION_MAJ) && payload_byte != TLS_MAJOR) ||
                    (p_w == SW'(OFS_HS_TYPE) && payload_byte != CLIENT_HELLO))
                begin
                    give_up = 1'b1;
                end
                else if (pos_next == tgt_next)
                begin
                    // skip the session id
                    t_w = off_w + b_w;
                    if (t_w + SW'(2) > tot_w)
                        give_up = 1'b1;
                    else
                    begin
                        tgt_next   = sat(t_w);
                        phase_next = PH_CS_HI;
                    end
                end
            end
            else if (pos_next == tgt_next)
            begin
                case (phase_next)
                    PH_CS_HI, PH_EL_HI, PH_ET_HI, PH_XL_HI, PH_NM_HI:
                    begin
                        hold_next  = payload_byte;
                        tgt_next   = sat(off_w);
                        phase_next = phase_t'(phase_next + 4'd1);
                    end
                    PH_CS_LO:
                    begin
                        t_w = off_w + hb_w;
                        if (t_w + SW'(1) > tot_w)
                            give_up = 1'b1;
                        else
                        begin
                            tgt_next   = sat(t_w);
                            phase_next = PH_COMP;
                        end
                    end
                    PH_COMP:
                    begin
                        t_w = off_w + b_w;
                        if (t_w + SW'(2) > tot_w)
                            give_up = 1'b1;
                        else
                        begin
                            tgt_next   = sat(t_w);
                            phase_next = PH_EL_HI;
                        end
                    end
                    PH_EL_LO:
                    begin
                        ext_end_next = sat(off_w + hb_w);
                        if (off_w + SW'(4) <= SW'(sat(off_w + hb_w)) &&
                            off_w + SW'(4) <= tot_w)
                        begin
                            tgt_next   = sat(off_w);
                            phase_next = PH_ET_HI;
                        end
                        else
                            give_up = 1'b1;
                    end
                    PH_ET_LO:
                    begin
                        ext_type_next = {hold_next, payload_byte};
                        tgt_next      = sat(off_w);
                        phase_next    = PH_XL_HI;
                    end
                    PH_XL_LO:
                    begin
                        if (ext_type_next == EXT_SERVER_NAME)
                        begin
                            // skip the server name list length
                            if (off_w + SW'(5) > tot_w)
                                give_up = 1'b1;
                            else
                            begin
                                tgt_next   = sat(off_w + SW'(2));
                                phase_next = PH_NT;
                            end
                        end
                        else
                        begin
                            t_w = SW'(sat(off_w + hb_w));
                            if (t_w + SW'(4) <= SW'(ext_end_next) &&
                                t_w + SW'(4) <= tot_w)
                            begin
                                tgt_next   = t_w[PW-1:0];
                                phase_next = PH_ET_HI;
                            end
                            else
                                give_up = 1'b1;
                        end
                    end
                    PH_NT:
                    begin
                        if (payload_byte != NAME_TYPE_HOST)
                            give_up = 1'b1;
                        else
                        begin
                            tgt_next   = sat(off_w);
                            phase_next = PH_NM_HI;
                        end
                    end
                    PH_NM_LO:
                    begin
                        if (hb_w == '0 || off_w + hb_w > tot_w)
                            give_up = 1'b1;
                        else
                        begin
                            remain_next = {hold_next, payload_byte};
                            tgt_next    = sat(off_w);
                            phase_next  = PH_NAME;
                        end
                    end
                    PH_NAME:
                    begin
                        kind        = KIND_NAME;
                        remain_next = remain_next - 16'd1;
                        tgt_next    = sat(off_w);
                        if (remain_next == 16'd0)
                        begin
                            fin          = 1'b1;
                            decided_next = 1'b1;
                            phase_next   = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        give_up = 1'b1;
                    end
                endcase
            end
        end

        if (give_up)
        begin
            decided_next = 1'b1;
            phase_next   = PH_IDLE;
            kind         = KIND_MISS;
            fin          = 1'b1;
        end

        pos_next = sat(SW'(pos_next) + SW'(1));

        // packet ends before a decision: a name in flight is cut short
        if (last_byte && !decided_next)
        begin
            if (kind != KIND_NAME)
                kind = KIND_MISS;
            fin          = 1'b1;
            decided_next = 1'b1;
            phase_next   = PH_IDLE;
        end
    end

    always_comb
    begin
        res.valid     = step_en && (kind != KIND_NONE);
        res.name_byte = (kind == KIND_NAME) ? payload_byte : 8'd0;
        res.found     = (kind == KIND_NAME);
        res.final_res = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            pos_reg      <= '0;
            tgt_reg      <= '0;
            ext_end_reg  <= '0;
            total_reg    <= '0;
            hold_reg     <= '0;
            ext_type_reg <= '0;
            remain_reg   <= '0;
            decided_reg  <= 1'b1;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            tgt_reg      <= tgt_next;
            ext_end_reg  <= ext_end_next;
            total_reg    <= total_next;
            hold_reg     <= hold_next;
            ext_type_reg <= ext_type_next;
            remain_reg   <= remain_next;
            decided_reg  <= decided_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tls_sni_extractor.sv =====
// Pulls the server name out of a TLS ClientHello carried in one TCP payload.
// Payload words stream in on the slave side, one byte each, with the total
// payload length on the first word (tuser high) and tlast on the final byte.
// For each packet the master side gives either the host-name bytes with
// tuser high and tlast on the last one, or a single word with tuser low and
// data zero when no server name is found; bytes after the decision give
// nothing. Throughput is one word per cycle while the master side does not
// stall; a word passes through an input register, the combinational parse
// step and the result register on its way out.

`default_nettype none

module tls_sni_extractor
    import tsni_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // payload_byte, payload_length
    input  wire logic        s_axis_tuser,   // first_byte
    input  wire logic        s_axis_tlast,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [7:0]  m_axis_tdata,   // name_byte
    output      logic        m_axis_tuser,   // found
    output      logic        m_axis_tlast
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic [15:0] in_len_reg;
    logic        in_first_reg;
    logic        in_last_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_found_reg;
    logic        out_final_reg;

    logic advance;
    logic step_en;
    logic in_take;
    res_t res;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? res.valid : out_valid_reg;

    tsni_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .payload_byte   (in_byte_reg),
        .payload_length (in_len_reg),
        .first_byte     (in_first_reg),
        .last_byte      (in_last_reg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= s_axis_tdata[7:0];
            in_len_reg   <= s_axis_tdata[23:8];
            in_first_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
        end
        if (advance && res.valid)
        begin
            out_byte_reg  <= res.name_byte;
            out_found_reg <= res.found;
            out_final_reg <= res.final_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_final_reg;

endmodule

`default_nettype wire

// ===== bench/tb_tls_sni_extractor.sv =====
`timescale 1ns / 1ps

module tb_tls_sni_extractor;
    import tsni_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 1900;
    localparam int unsigned LEN_MASK = (1 << LENGTH_WIDTH_DEF) - 1;
    localparam int unsigned OFS_MAX = (1 << (LENGTH_WIDTH_DEF + 1)) - 1;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       found;
        logic       final_res;
    } sni_word_t;

    typedef enum logic [1:0] {
        RX_FREE     = 2'd0,
        RX_COIN     = 2'd1,
        RX_PERIODIC = 2'd2,
        RX_SPARSE   = 2'd3
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // payload_byte, payload_length
    logic        s_axis_tuser = 1'b0; // first_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // name_byte
    logic        m_axis_tuser;        // found
    logic        m_axis_tlast;

    // parser state mirrored for prediction
    phase_t      hello_phase;
    int unsigned hello_pos;
    int unsigned hello_target;
    int unsigned hello_ext_end;
    int unsigned hello_total;
    int unsigned hello_hold;
    int unsigned hello_ext_type;
    int unsigned hello_name_left;
    bit          hello_done;

    sni_word_t   name_q[$];
    sni_word_t   got_word;
    sni_word_t   want_word;
    logic [7:0]  pkt[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          packet_words = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int          rx_left = 0;

    tls_sni_extractor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern, switching to a randomly chosen style when each run ends
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(50, 300);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            RX_FREE:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_axis_tready <= (cycle_count % 5) != 0;
            default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic int unsigned clamp_ofs(input int unsigned v);
        return (v > OFS_MAX) ? OFS_MAX : v;
    endfunction

    function automatic void add_byte(input logic [7:0] v);
        pkt.insert(pkt.size(), v);
    endfunction

    function automatic res_kind_t hello_abandon();
        hello_done = 1'b1;
        hello_phase = PH_IDLE;
        return KIND_MISS;
    endfunction

    function automatic res_kind_t hello_next_ext(input int unsigned ofs);
        if (ofs + 4 <= hello_ext_end && ofs + 4 <= hello_total)
        begin
            hello_target = clamp_ofs(ofs);
            hello_phase = PH_ET_HI;
            return KIND_NONE;
        end
        return hello_abandon();
    endfunction

    // advance the mirrored parser by one payload word, queue any name word it yields
    function automatic void hello_predict(input logic [7:0] b, input logic [15:0] len_in,
                                          input logic first, input logic last);
        res_kind_t   kind;
        logic        fin;
        int unsigned p;
        int unsigned t;
        int unsigned ofs;
        int unsigned n;
        kind = KIND_NONE;
        fin = 1'b0;
        if (first)
        begin
            hello_done = 1'b0;
            hello_phase = PH_HEADER;
            hello_pos = 0;
            hello_total = len_in & LEN_MASK;
            hello_target = OFS_SESSION_ID;
            hello_ext_end = 0;
            hello_hold = 0;
            hello_ext_type = 0;
            hello_name_left = 0;
            if (hello_total < MIN_HELLO_LEN)
                kind = hello_abandon();
        end
        if (!hello_done && kind == KIND_NONE)
        begin
            p = hello_pos;
            if (hello_phase == PH_HEADER)
            begin
                if ((p == OFS_CONTENT_TYPE && b != TLS_HANDSHAKE) ||
                    (p == OFS_VERSION_MAJ && b != TLS_MAJOR) ||
                    (p == OFS_HS_TYPE && b != CLIENT_HELLO))
                    kind = hello_abandon();
                else if (p == hello_target)
                begin
                    t = p + 1 + b;
                    if (t + 2 > hello_total)
                        kind = hello_abandon();
                    else
                    begin
                        hello_target = clamp_ofs(t);
                        hello_phase = PH_CS_HI;
                    end
                end
            end
            else if (p == hello_target)
            begin
                n = (hello_hold << 8) | b;
                case (hello_phase)
                    PH_CS_HI, PH_EL_HI, PH_ET_HI, PH_XL_HI, PH_NM_HI:
                    begin
                        hello_hold = b;
                        hello_target = clamp_ofs(p + 1);
                        hello_phase = phase_t'(hello_phase + 4'd1);
                    end
                    PH_CS_LO:
                    begin
                        t = p + 1 + n;
                        if (t + 1 > hello_total)
                            kind = hello_abandon();
                        else
                        begin
                            hello_target = clamp_ofs(t);
                            hello_phase = PH_COMP;
                        end
                    end
                    PH_COMP:
                    begin
                        t = p + 1 + b;
                        if (t + 2 > hello_total)
                            kind = hello_abandon();
                        else
                        begin
                            hello_target = clamp_ofs(t);
                            hello_phase = PH_EL_HI;
                        end
                    end
                    PH_EL_LO:
                    begin
                        ofs = p + 1;
                        hello_ext_end = clamp_ofs(ofs + n);
                        kind = hello_next_ext(ofs);
                    end
                    PH_ET_LO:
                    begin
                        hello_ext_type = n;
                        hello_target = clamp_ofs(p + 1);
                        hello_phase = PH_XL_HI;
                    end
                    PH_XL_LO:
                    begin
                        ofs = p + 1;
                        if (hello_ext_type == EXT_SERVER_NAME)
                        begin
                            if (ofs + 5 > hello_total)
                                kind = hello_abandon();
                            else
                            begin
                                // skip the server name list length
                                hello_target = clamp_ofs(ofs + 2);
                                hello_phase = PH_NT;
                            end
                        end
                        else
                            kind = hello_next_ext(clamp_ofs(ofs + n));
                    end
                    PH_NT:
                    begin
                        if (b != NAME_TYPE_HOST)
                            kind = hello_abandon();
                        else
                        begin
                            hello_target = clamp_ofs(p + 1);
                            hello_phase = PH_NM_HI;
                        end
                    end
                    PH_NM_LO:
                    begin
                        ofs = p + 1;
                        if (n == 0 || ofs + n > hello_total)
                            kind = hello_abandon();
                        else
                        begin
                            hello_name_left = n & 16'hFFFF;
                            hello_target = clamp_ofs(ofs);
                            hello_phase = PH_NAME;
                        end
                    end
                    PH_NAME:
                    begin
                        kind = KIND_NAME;
                        hello_name_left = (hello_name_left - 1) & 16'hFFFF;
                        hello_target = clamp_ofs(p + 1);
                        if (hello_name_left == 0)
                        begin
                            fin = 1'b1;
                            hello_done = 1'b1;
                            hello_phase = PH_IDLE;
                        end
                    end
                    default:
                        kind = hello_abandon();
                endcase
            end
        end
        hello_pos = clamp_ofs(hello_pos + 1);
        if (kind == KIND_MISS)
            fin = 1'b1;
        if (last && !hello_done)
        begin
            if (kind != KIND_NAME)
                kind = KIND_MISS;
            fin = 1'b1;
            hello_done = 1'b1;
            hello_phase = PH_IDLE;
        end
        if (kind != KIND_NONE)
            name_q.insert(name_q.size(),
                          sni_word_t'{(kind == KIND_NAME) ? b : 8'h00, kind == KIND_NAME, fin});
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_word = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
            if (name_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: data %02h found %0b last %0b",
                             got_word.name_byte, got_word.found, got_word.final_res);
            end
            else
            begin
                want_word = name_q.pop_front();
                if (got_word !== want_word)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected data %02h found %0b last %0b, got %02h %0b %0b",
                                 want_word.name_byte, want_word.found, want_word.final_res,
                                 got_word.name_byte, got_word.found, got_word.final_res);
                end
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic [15:0] len,
                             input logic first, input logic last);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 9) == 0) ? 400 : $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {len, b};
        s_axis_tuser <= first;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hello_predict(b, len, first, last);
        burst_left--;
    endtask

    task automatic send_packet(input logic [15:0] len_field, input int stop, input bit mark_last);
        for (int i = 0; i <= stop; i++)
            send_word(pkt[i], (i == 0) ? len_field : 16'($urandom), i == 0,
                      mark_last && i == stop);
        packet_words += stop + 1;
    endtask

    task automatic send_noise(input int count);
        repeat (count)
            send_word(8'($urandom), 16'($urandom), 1'b0, 1'($urandom_range(0, 1)));
    endtask

    // lay out a client hello in pkt with the given field sizes
    task automatic build_hello(input int sid_len, input int cs_len, input int comp_len,
                               input int others, input bit with_sni,
                               input logic [7:0] host_kind, input int host_len);
        int          ext_at;
        int          ext_len;
        int          xl;
        logic [15:0] xt;
        pkt.delete();
        repeat (OFS_SESSION_ID)
            add_byte(8'($urandom));
        pkt[OFS_CONTENT_TYPE] = TLS_HANDSHAKE;
        pkt[OFS_VERSION_MAJ] = TLS_MAJOR;
        pkt[OFS_HS_TYPE] = CLIENT_HELLO;
        add_byte(8'(sid_len));
        repeat (sid_len) add_byte(8'($urandom));
        add_byte(8'(cs_len >> 8));
        add_byte(8'(cs_len));
        repeat (cs_len) add_byte(8'($urandom));
        add_byte(8'(comp_len));
        repeat (comp_len) add_byte(8'($urandom));
        ext_at = pkt.size();
        add_byte(8'h00);
        add_byte(8'h00);
        repeat (others)
        begin
            xt = 16'($urandom);
            if (xt == EXT_SERVER_NAME)
                xt = 16'h000a;
            xl = $urandom_range(0, 6);
            add_byte(xt[15:8]);
            add_byte(xt[7:0]);
            add_byte(8'(xl >> 8));
            add_byte(8'(xl));
            repeat (xl) add_byte(8'($urandom));
        end
        if (with_sni)
        begin
            add_byte(EXT_SERVER_NAME[15:8]);
            add_byte(EXT_SERVER_NAME[7:0]);
            add_byte(8'((host_len + 5) >> 8));
            add_byte(8'(host_len + 5));
            add_byte(8'((host_len + 3) >> 8));
            add_byte(8'(host_len + 3));
            add_byte(host_kind);
            add_byte(8'(host_len >> 8));
            add_byte(8'(host_len));
            repeat (host_len) add_byte(8'($urandom_range(8'h2d, 8'h7a)));
        end
        ext_len = pkt.size() - ext_at - 2;
        pkt[ext_at] = 8'(ext_len >> 8);
        pkt[ext_at + 1] = 8'(ext_len);
    endtask

    task automatic test_idle_words();
        send_word(8'h00, 16'h0000, 1'b0, 1'b0);
        send_word(8'hFF, 16'hFFFF, 1'b0, 1'b1);
        send_word(TLS_HANDSHAKE, 16'd100, 1'b0, 1'b0);
    endtask

    task automatic test_good_hello();
        build_hello(32, 2, 1, 2, 1'b1, NAME_TYPE_HOST, 10);
        pkt[pkt.size() - 2] = 8'h00;
        pkt[pkt.size() - 1] = 8'hFF;
        send_packet(16'(pkt.size()), pkt.size() - 1, 1'b1);
        // minimal hello, then bytes past the length that must be ignored
        build_hello(0, 0, 0, 0, 1'b1, NAME_TYPE_HOST, 1);
        add_byte(8'h41);
        add_byte(8'h42);
        send_packet(16'(pkt.size() - 2), pkt.size() - 1, 1'b1);
        send_noise(2);
    endtask

    task automatic test_header_checks();
        build_hello(4, 2, 1, 0, 1'b1, NAME_TYPE_HOST, 3);
        pkt[OFS_CONTENT_TYPE] = 8'h17;
        send_packet(16'(pkt.size()), pkt.size() - 1, 1'b1);
        pkt[OFS_CONTENT_TYPE] = TLS_HANDSHAKE;
        pkt[OFS_VERSION_MAJ] = 8'h02;
        send_packet(16'(pkt.size()), pkt.size() - 1, 1'b1);
        pkt[OFS_VERSION_MAJ] = TLS_MAJOR;
        pkt[OFS_HS_TYPE] = 8'h02;
        send_packet(16'(pkt.size()), pkt.size() - 1, 1'b1);
        pkt[OFS_HS_TYPE] = CLIENT_HELLO;
        send_packet(16'(MIN_HELLO_LEN - 1), pkt.size() - 1, 1'b1);
        send_packet(16'(MIN_HELLO_LEN), pkt.size() - 1, 1'b1);
        send_packet(16'h0000, 0, 1'b1);
        // session id runs past the payload length
        build_hello(32, 2, 1, 0, 1'b1, NAME_TYPE_HOST, 3);
        send_packet(16'd60, pkt.size() - 1, 1'b1);
    endtask

    task automatic test_bad_names();
        build_hello(0, 4, 1, 1, 1'b1, 8'h01, 5);
        send_packet(16'(pkt.size()), pkt.size() - 1, 1'b1);
        build_hello(0, 4, 1, 1, 1'b1, NAME_TYPE_HOST, 0);
        send_packet(16'(pkt.size()), pkt.size() - 1, 1'b1);
        build_hello(0, 4, 1, 0, 1'b1, NAME_TYPE_HOST, 6);
        send_packet(16'(pkt.size() - 1), pkt.size() - 1, 1'b1);
        build_hello(2, 2, 1, 3, 1'b0, NAME_TYPE_HOST, 0);
        send_packet(16'(pkt.size()), pkt.size() - 1, 1'b1);
    endtask

    task automatic test_early_last();
        build_hello(1, 2, 1, 1, 1'b1, NAME_TYPE_HOST, 8);
        send_packet(16'(pkt.size()), 20, 1'b1);
        send_packet(16'(pkt.size()), pkt.size() - 4, 1'b1);
        // oversized length: the name is still taken whole
        send_packet(16'hFFFF, pkt.size() - 1, 1'b1);
    endtask

    task automatic test_restart();
        build_hello(0, 2, 1, 1, 1'b1, NAME_TYPE_HOST, 6);
        send_packet(16'(pkt.size()), pkt.size() - 3, 1'b0);
        send_packet(16'(pkt.size()), pkt.size() - 1, 1'b1);
    endtask

    task automatic test_random_hellos();
        int          shape;
        int          stop;
        int          extra;
        bit          mark_last;
        logic [15:0] len_field;
        while (packet_words < RANDOM_WORDS)
        begin
            build_hello(($urandom_range(0, 3) == 0) ? 32 : $urandom_range(0, 8),
                        $urandom_range(0, 8), $urandom_range(0, 2), $urandom_range(0, 3),
                        $urandom_range(0, 11) != 0,
                        ($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255))
                                                     : NAME_TYPE_HOST,
                        ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 16));
            len_field = 16'(pkt.size());
            extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            repeat (extra) add_byte(8'($urandom));
            stop = pkt.size() - 1;
            mark_last = 1'b1;
            shape = $urandom_range(0, 99);
            if (shape < 55)
                ;
            else if (shape < 65)
                pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
            else if (shape < 72)
                len_field = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                       : 16'(len_field - $urandom_range(1, 12));
            else if (shape < 82)
                stop = $urandom_range(0, pkt.size() - 1);
            else if (shape < 92)
            begin
                stop = $urandom_range(0, pkt.size() - 1);
                mark_last = 1'b0;
            end
            else
                len_field = 16'($urandom_range(int'(len_field), 65535));
            send_packet(len_field, stop, mark_last);
            if ($urandom_range(0, 5) == 0)
                send_noise($urandom_range(1, 4));
        end
    endtask

    initial
    begin
        hello_phase = PH_IDLE;
        hello_pos = 0;
        hello_target = 0;
        hello_ext_end = 0;
        hello_total = 0;
        hello_hold = 0;
        hello_ext_type = 0;
        hello_name_left = 0;
        hello_done = 1'b1;
        name_q.delete();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_words();
        test_good_hello();
        test_header_checks();
        test_bad_names();
        test_early_last();
        test_restart();
        test_random_hellos();
        s_axis_tvalid <= 1'b0;
        while (name_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== tls_sni_extractor.f =====
hdl/tsni_pkg.sv
hdl/tsni_parser.sv
hdl/tls_sni_extractor.sv
bench/tb_tls_sni_extractor.sv
